### hdl/rusi_pkg.sv
// shared constants for the ray versus unit box slab test
package rusi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned NUM_W         = VAL_W + 2;
  localparam int unsigned THR_W         = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd655;
  localparam logic signed [VAL_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] T_MIN = 32'sh8000_0000;
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 72;

  // flags of one axis that ride alongside its divider pair
  typedef struct packed {
    logic par;      // axis treated as parallel
    logic lo_pos;   // lower numerator above zero
    logic hi_neg;   // upper numerator below zero
    logic lo_neg_q; // lower quotient is negative
    logic hi_neg_q; // upper quotient is negative
  } axis_side_t;

endpackage

### hdl/rusi_div.sv
// pipelined restoring divider, one quotient bit per stage, overflow flag
module rusi_div
  import rusi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [NUM_W+FRAC_BITS-2:0]    mag_i,  // magnitude of numerator times 2^FRAC_BITS
  input  logic [VAL_W-1:0]              den_i,
  output logic [VAL_W-1:0]              quo_o,
  output logic                          ovf_o
);

  localparam int unsigned NW = NUM_W + FRAC_BITS - 1;

  logic [VAL_W-1:0] rem_q [0:VAL_W];
  logic [VAL_W-1:0] low_q [0:VAL_W];
  logic [VAL_W-1:0] den_q [0:VAL_W];
  logic [VAL_W-1:0] quo_q [0:VAL_W];
  logic             ovf_q [0:VAL_W];

  logic [NW-1:0]    hi_part;
  assign hi_part = mag_i >> VAL_W;

  // prep stage: a quotient of 2^32 or more raises the overflow flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= VAL_W'(hi_part);
      low_q[0] <= mag_i[VAL_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (33'(hi_part) >= {1'b0, den_i});
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < VAL_W; k++) begin : g_step
    logic [VAL_W:0] trial;
    logic           take;
    assign trial = {rem_q[k], low_q[k][VAL_W-1]};
    assign take  = (trial >= {1'b0, den_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? VAL_W'(trial - {1'b0, den_q[k]}) : trial[VAL_W-1:0];
        low_q[k+1] <= {low_q[k][VAL_W-2:0], 1'b0};
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][VAL_W-2:0], take};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[VAL_W];
  assign ovf_o = ovf_q[VAL_W];

endmodule

### hdl/ray_unit_box_slab_intersect.sv
// top level: streaming slab test of a ray against the unit box
// Takes one ray per cycle while the output side does not stall and gives one
// result per ray. The pipeline is built from the six pipelined dividers
// (one prep stage plus one stage per quotient bit), with one input stage, one
// per-axis ordering stage and one output stage around them. The whole pipeline
// advances together; it halts only while a finished result waits at the
// output. parallel_threshold is written through cfg_we_i; the user must do so
// only while the pipeline is empty, as the block itself does not enforce it.
module ray_unit_box_slab_intersect
  import rusi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [THR_W-1:0]       cfg_wdata_i,   // parallel_threshold
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // hit, entry_t (32), exit_t (32), zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned NW      = NUM_W + FRAC_BITS - 1;
  localparam int unsigned DIV_LAT = VAL_W + 1;
  localparam logic signed [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

  logic [THR_W-1:0] thr_q;
  logic             en;
  logic             v1_q;
  logic             vd_q [1:DIV_LAT];
  logic             vs_q;
  logic             vo_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // whole pipeline moves unless the output holds an untaken result
  assign en              = !vo_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vs_q <= 1'b0;
      vo_q <= 1'b0;
      for (int i = 1; i <= DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid_i;
      vd_q[1] <= v1_q;
      for (int i = 2; i <= DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
      vs_q    <= vd_q[DIV_LAT];
      vo_q    <= vs_q;
    end
  end

  logic signed [VAL_W-1:0] ent_q [0:2];
  logic signed [VAL_W-1:0] ext_q [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [VAL_W-1:0] o_in, d_in;
    logic [VAL_W-1:0]        d_abs;
    logic signed [NUM_W-1:0] nlo_q, nhi_q;
    logic [VAL_W-1:0]        dabs_q;
    logic                    dneg_q, par_q;
    logic [NW-1:0]           mlo, mhi;
    logic [VAL_W-1:0]        qlo, qhi;
    logic                    olo, ohi;
    axis_side_t              side_in;
    axis_side_t              side_q [1:DIV_LAT];
    axis_side_t              sd;
    logic signed [VAL_W-1:0] slo, shi;

    assign o_in  = s_axis_tdata_i[a*VAL_W +: VAL_W];
    assign d_in  = s_axis_tdata_i[(a+3)*VAL_W +: VAL_W];
    assign d_abs = d_in[VAL_W-1] ? (VAL_W'(0) - d_in) : d_in;

    // input stage: numerators, direction magnitude, parallel test
    always_ff @(posedge clk_i) begin
      if (en) begin
        nlo_q  <= -ONE - NUM_W'(o_in);
        nhi_q  <= ONE - NUM_W'(o_in);
        dabs_q <= d_abs;
        dneg_q <= d_in[VAL_W-1];
        par_q  <= (d_in == '0) || (d_abs < VAL_W'(thr_q));
      end
    end

    assign mlo = NW'(nlo_q[NUM_W-1] ? (NUM_W'(0) - nlo_q) : nlo_q) << FRAC_BITS;
    assign mhi = NW'(nhi_q[NUM_W-1] ? (NUM_W'(0) - nhi_q) : nhi_q) << FRAC_BITS;

    rusi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mlo),
      .den_i (dabs_q),
      .quo_o (qlo),
      .ovf_o (olo)
    );

    rusi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mhi),
      .den_i (dabs_q),
      .quo_o (qhi),
      .ovf_o (ohi)
    );

    // flags travel beside the dividers
    assign side_in.par      = par_q;
    assign side_in.lo_pos   = !nlo_q[NUM_W-1] && (nlo_q != '0);
    assign side_in.hi_neg   = nhi_q[NUM_W-1];
    assign side_in.lo_neg_q = nlo_q[NUM_W-1] ^ dneg_q;
    assign side_in.hi_neg_q = nhi_q[NUM_W-1] ^ dneg_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[1] <= side_in;
        for (int i = 2; i <= DIV_LAT; i++) side_q[i] <= side_q[i-1];
      end
    end

    assign sd = side_q[DIV_LAT];

    // saturate quotients to the signed range
    always_comb begin
      if (sd.lo_neg_q) begin
        slo = (olo || (qlo[VAL_W-1] && (qlo[VAL_W-2:0] != '0))) ? T_MIN
              : VAL_W'(VAL_W'(0) - qlo);
      end else begin
        slo = (olo || qlo[VAL_W-1]) ? T_MAX : qlo;
      end
      if (sd.hi_neg_q) begin
        shi = (ohi || (qhi[VAL_W-1] && (qhi[VAL_W-2:0] != '0))) ? T_MIN
              : VAL_W'(VAL_W'(0) - qhi);
      end else begin
        shi = (ohi || qhi[VAL_W-1]) ? T_MAX : qhi;
      end
    end

    // per-axis entry and exit
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sd.par) begin
          ent_q[a] <= sd.lo_pos ? T_MAX : T_MIN;
          ext_q[a] <= sd.hi_neg ? T_MIN : T_MAX;
        end else if (slo > shi) begin
          ent_q[a] <= shi;
          ext_q[a] <= slo;
        end else begin
          ent_q[a] <= slo;
          ext_q[a] <= shi;
        end
      end
    end
  end

  // combine axes into the output register
  logic signed [VAL_W-1:0] ent01, ext01, ent_all, ext_all;
  logic signed [VAL_W-1:0] ent_o_q, ext_o_q;
  logic                    hit_o_q;

  assign ent01   = (ent_q[1] > ent_q[0]) ? ent_q[1] : ent_q[0];
  assign ext01   = (ext_q[1] < ext_q[0]) ? ext_q[1] : ext_q[0];
  assign ent_all = (ent_q[2] > ent01) ? ent_q[2] : ent01;
  assign ext_all = (ext_q[2] < ext01) ? ext_q[2] : ext01;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_o_q <= ent_all;
      ext_o_q <= ext_all;
      hit_o_q <= (ent_all <= ext_all);
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 2*VAL_W - 1)'(0), ext_o_q, ent_o_q, hit_o_q};

endmodule
